### sv/sle_pkg.sv
// Shared types and constants for the sorted list engine.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int SLE_DEPTH  = 16;
  localparam int SLE_QDEPTH = 2;

  localparam int OPC_W  = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;

  localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPC_W-1:0] OP_SEARCH = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    KIND_APPEND,
    KIND_INSERT,
    KIND_DELETE,
    KIND_SEARCH
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CMP,
    BK_APPLY
  } bk_state_t;

  typedef struct packed {
    logic [OPC_W-1:0]        opcode;
    logic signed [VAL_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

### sv/sle_front.sv
// Front end: takes command beats, decodes the opcode and queues the command.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_front import sle_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output cmd_t     q_cmd
);

  localparam int QW = (SLE_QDEPTH > 1) ? $clog2(SLE_QDEPTH) : 1;
  localparam int FW = $clog2(SLE_QDEPTH + 1);
  localparam logic [QW-1:0] Q_LAST = QW'(SLE_QDEPTH - 1);
  localparam logic [FW-1:0] Q_FULL = FW'(SLE_QDEPTH);

  cmd_t          slot_r [SLE_QDEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  cmd_t          dec_cmd;
  logic          push;

  always_comb begin
    dec_cmd.value = in_data.operand_value;
    unique case (in_data.opcode)
      OP_APPEND: dec_cmd.kind = KIND_APPEND;
      OP_INSERT: dec_cmd.kind = KIND_INSERT;
      OP_DELETE: dec_cmd.kind = KIND_DELETE;
      OP_SEARCH: dec_cmd.kind = KIND_SEARCH;
      default:   dec_cmd.kind = KIND_SEARCH;
    endcase
  end

  assign in_stall = (fill_r == Q_FULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (q_pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

endmodule

### sv/sle_back.sv
// Back end: row of compare-and-shift cells holding the table, plus result register.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_back import sle_pkg::*; #(
  parameter int DEPTH = SLE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_pop,
  input  cmd_t    q_cmd,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bk_state_t               state_r, state_nxt;
  cmd_t                    cmd_r;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [VAL_W-1:0] ent_r   [DEPTH];
  logic signed [VAL_W-1:0] ent_nxt [DEPTH];
  logic [DEPTH-1:0]        hit_r, hit_nxt;
  logic                    full_r;
  result_t                 res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [DEPTH:0]          seen;
  logic [DEPTH-1:0]        first;
  logic [DEPTH-1:0]        after;
  logic [IW-1:0]           hit_idx;
  logic [IW-1:0]           pos_idx;
  logic [IW+POS_W-1:0]     pos_wide;
  logic [CW+CNT_W-1:0]     cnt_wide;
  logic                    any_hit;
  logic                    commit;
  logic                    wr_ins;
  logic                    wr_del;

  // compare stage
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_nxt[i] = 1'b0;
      if (CW'(i) < count_r) begin
        unique case (cmd_r.kind)
          KIND_INSERT:              hit_nxt[i] = !(ent_r[i] < cmd_r.value);
          KIND_DELETE, KIND_SEARCH: hit_nxt[i] = (ent_r[i] == cmd_r.value);
          KIND_APPEND:              hit_nxt[i] = 1'b0;
          default:                  hit_nxt[i] = 1'b0;
        endcase
      end
    end
  end

  // first-match chain and target position
  always_comb begin
    seen[0] = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      seen[i+1] = seen[i] | hit_r[i];
      first[i]  = hit_r[i] & ~seen[i];
      if (first[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
    any_hit = seen[DEPTH];
    for (int i = 0; i < DEPTH; i++) begin
      after[i] = any_hit ? seen[i+1] : (CW'(i) >= count_r);
    end
    pos_idx = any_hit ? hit_idx : count_r[IW-1:0];
  end

  // shift network: insert moves up from the target, delete closes the gap
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (wr_ins && after[i]) begin
        if ((i == 0) || !after[(i == 0) ? 0 : i - 1]) begin
          ent_nxt[i] = cmd_r.value;
        end else begin
          ent_nxt[i] = ent_r[(i == 0) ? 0 : i - 1];
        end
      end else if (wr_del && after[i]) begin
        ent_nxt[i] = ent_r[(i == DEPTH - 1) ? i : i + 1];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    commit        = 1'b0;
    wr_ins        = 1'b0;
    wr_del        = 1'b0;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    pos_wide      = '0;
    cnt_wide      = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_CMP;
        end
      end
      BK_CMP: begin
        state_nxt = BK_APPLY;
      end
      BK_APPLY: begin
        if (!out_valid_r || !out_stall) begin
          commit         = 1'b1;
          out_valid_nxt  = 1'b1;
          res_nxt.status = ST_OK;
          unique case (cmd_r.kind)
            KIND_APPEND, KIND_INSERT: begin
              if (full_r) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_ins    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            KIND_DELETE: begin
              if (!any_hit) begin
                res_nxt.status = ST_NOT_FOUND;
              end else begin
                wr_del    = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            KIND_SEARCH: begin
              if (!any_hit) begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            default: res_nxt.status = ST_NOT_FOUND;
          endcase
          pos_wide = {{POS_W{1'b0}}, pos_idx};
          cnt_wide = {{CNT_W{1'b0}}, count_nxt};
          res_nxt.position    = (res_nxt.status == ST_OK) ? pos_wide[POS_W-1:0] : '0;
          res_nxt.entry_count = cnt_wide[CNT_W-1:0];
          if (q_valid) begin
            q_pop     = 1'b1;
            state_nxt = BK_CMP;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (state_r == BK_CMP) begin
      hit_r  <= hit_nxt;
      full_r <= (count_r == FULL_CNT);
    end
    if (commit) begin
      res_r <= res_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

### sv/sorted_list_engine_core.sv
// Sorted list engine top level: front decode queue feeding the cell-row back end.
// Depends on sle_pkg, sle_front and sle_back.
`timescale 1ns / 1ps

// Holds an ordered table of up to DEPTH signed 32-bit values and runs one
// command per input beat (append, sorted insert, delete first match, search),
// returning one result beat with status, position and entry count. Each command
// passes through the two-entry command queue and then the back end, which
// compares the operand against every cell (BK_CMP) and then shifts the cell row
// and loads the result register (BK_APPLY), whatever the table length; the back
// end handles one command at a time and holds in BK_APPLY while a result waits.
// Input is taken while a finished result is still waiting on out_stall.

module sorted_list_engine_core import sle_pkg::*; #(
  parameter int DEPTH = SLE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_data
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  sle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  sle_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/sle_checker.sv
// Port-level checks for sorted_list_engine_core, bound to the top level.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_checker import sle_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.position == '0))
    else $error("failed command reports a position");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.entry_count != '0))
    else $error("full status with empty table");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
